// ----- rtl/fixed_block_pool_allocator_macros.svh -----
// Assertion macros shared by the allocator's checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define FBPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fbpa_pkg.sv -----
// Package with word types, codes and controller/datapath interface structs.
package fbpa_pkg;

    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 32;
    localparam int SIZE_W      = 25;
    localparam int CNT_FIELD_W = 11;
    localparam int STATUS_W    = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC_OK   = 4'd0,
        ST_OVERSIZE   = 4'd1,
        ST_EMPTY      = 4'd2,
        ST_FREED      = 4'd3,
        ST_FOREIGN    = 4'd4,
        ST_NULL       = 4'd5,
        ST_MISALIGNED = 4'd6,
        ST_BAD_INDEX  = 4'd7,
        ST_OVERFREE   = 4'd8
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_BLOCK_SIZE  = 2'd1,
        CFG_BLOCK_COUNT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                   kind;
        logic [LEN_W-1:0]       request_len;
        logic [ADDR_W-1:0]      free_addr;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ADDR_W-1:0]      block_addr;
        logic [CNT_FIELD_W-1:0] free_blocks;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    eval;
        logic    mul_idx;
        logic    div_start;
        logic    div_step;
        logic    pop;
        logic    push;
        logic    result;
        status_t code;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic kind_free;
        logic oversize;
        logic empty;
        logic is_null;
        logic foreign;
        logic div_last;
        logic misaligned;
        logic bad_index;
        logic top_zero;
    } dp_flags_t;

endpackage

// ----- rtl/fbpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module fbpa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/fbpa_ctrl.sv -----
// Controller state machine sequencing allocate and free requests.
module fbpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic                cfg_ready,
    input  fbpa_pkg::dp_flags_t flags,
    output fbpa_pkg::dp_cmd_t   cmd
);

    import fbpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CLASS,
        S_ADDR,
        S_DIV,
        S_CHECK,
        S_OUT
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    rsp_valid_reg, rsp_valid_next;

    // Next state, result code and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        cmd.code       = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                if (flags.kind_free == KIND_ALLOC)
                begin
                    if (flags.oversize)
                    begin
                        code_next  = ST_OVERSIZE;
                        state_next = S_OUT;
                    end
                    else if (flags.empty)
                    begin
                        code_next  = ST_EMPTY;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.mul_idx = 1'b1;
                        state_next  = S_ADDR;
                    end
                end
                else
                begin
                    if (flags.is_null)
                    begin
                        code_next  = ST_NULL;
                        state_next = S_OUT;
                    end
                    else if (flags.foreign)
                    begin
                        code_next  = ST_FOREIGN;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_ADDR:
            begin
                cmd.pop    = 1'b1;
                code_next  = ST_ALLOC_OK;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (flags.div_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (flags.misaligned)
                begin
                    code_next = ST_MISALIGNED;
                end
                else if (flags.bad_index)
                begin
                    code_next = ST_BAD_INDEX;
                end
                else if (flags.top_zero)
                begin
                    code_next = ST_OVERFREE;
                end
                else
                begin
                    cmd.push  = 1'b1;
                    code_next = ST_FREED;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Load the output word once the previous one is gone
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.result     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= ST_ALLOC_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    // Take config only with no request offered, in flight or waiting at the output
    assign cfg_ready = (state_reg == S_IDLE) && !rsp_valid_reg && !req_valid;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- rtl/fbpa_dp.sv -----
// Datapath: config registers, free stack, multiplier and restoring divider.
module fbpa_dp #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fbpa_pkg::req_t                        req,
    input  fbpa_pkg::dp_cmd_t                     cmd,
    input  logic                                  cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]           cfg_data,
    output fbpa_pkg::dp_flags_t                   flags,
    output fbpa_pkg::rsp_t                        rsp
);

    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W = SIZE_W + CNT_W;
    localparam int DC_W  = $clog2(CNT_W);
    localparam logic [CNT_W-1:0] CNT_RST =
        CNT_W'((MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024);

    // Configuration
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] size_cfg;
    logic [31:0]       cnt_raw;
    logic [CNT_W-1:0]  cnt_cfg;
    logic              cfg_hit;

    // Stack pointer and fill mark
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic [CNT_W-1:0]  top_inc, top_dec;

    // Captured request and first-stage values
    logic              kind_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] off_reg;
    logic              below_reg;

    // Multiplier, divider and result
    logic [CNT_W-1:0]  mul_b;
    logic [OFF_W-1:0]  mul_reg;
    logic [OFF_W-1:0]  rem_reg;
    logic [OFF_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  quo_reg;
    logic [DC_W-1:0]   dcnt_reg;
    logic              rem_ge;
    logic [ADDR_W-1:0] baddr_reg;
    rsp_t              rsp_reg;

    // Stack memory
    logic [IDX_W-1:0]  ram_rd;
    logic [IDX_W-1:0]  idx;

    // Decode configuration writes
    assign size_cfg = (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1) : cfg_data[SIZE_W-1:0];
    assign cnt_raw  = 32'(cfg_data[CNT_FIELD_W-1:0]);
    assign cnt_cfg  = (cnt_raw == 32'd0) ? CNT_W'(1) :
                      (cnt_raw > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(cnt_raw);
    assign cfg_hit  = cfg_we && ((cfg_index == CFG_POOL_BASE) ||
                                 (cfg_index == CFG_BLOCK_SIZE) ||
                                 (cfg_index == CFG_BLOCK_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= ADDR_W'(4096);
            size_reg  <= SIZE_W'(64);
            count_reg <= CNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_BASE:   base_reg  <= cfg_data;
                CFG_BLOCK_SIZE:  size_reg  <= size_cfg;
                CFG_BLOCK_COUNT: count_reg <= cnt_cfg;
                default:         base_reg  <= base_reg;
            endcase
        end
    end

    // Advance the stack pointer; entries at or above the fill mark read as identity
    assign top_inc = top_reg + CNT_W'(1);
    assign top_dec = top_reg - CNT_W'(1);

    always_comb
    begin
        top_next = top_reg;
        hw_next  = hw_reg;
        if (cfg_hit)
        begin
            top_next = '0;
            hw_next  = '0;
        end
        else if (cmd.pop)
        begin
            top_next = top_inc;
            if (top_inc > hw_reg)
            begin
                hw_next = top_inc;
            end
        end
        else if (cmd.push)
        begin
            top_next = top_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            hw_reg  <= '0;
        end
        else
        begin
            top_reg <= top_next;
            hw_reg  <= hw_next;
        end
    end

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (top_dec[IDX_W-1:0]),
        .wr_data (quo_reg[IDX_W-1:0]),
        .rd_en   (cmd.eval),
        .rd_addr (top_reg[IDX_W-1:0]),
        .rd_data (ram_rd)
    );

    assign idx = (top_reg < hw_reg) ? ram_rd : top_reg[IDX_W-1:0];

    // Capture the request word and take the offset from the pool base
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= req.kind;
            len_reg  <= req.request_len;
            addr_reg <= req.free_addr;
        end
        if (cmd.eval)
        begin
            off_reg   <= addr_reg - base_reg;
            below_reg <= (addr_reg < base_reg);
        end
    end

    // Shared multiplier: pool extent first, then block offset for an allocate
    assign mul_b = cmd.mul_idx ? CNT_W'(idx) : count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.eval || cmd.mul_idx)
        begin
            mul_reg <= OFF_W'(size_reg) * OFF_W'(mul_b);
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign rem_ge = (rem_reg >= dvs_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= off_reg[OFF_W-1:0];
            dvs_reg  <= OFF_W'(size_reg) << (CNT_W - 1);
            quo_reg  <= '0;
            dcnt_reg <= DC_W'(CNT_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg  <= dvs_reg >> 1;
            quo_reg  <= {quo_reg[CNT_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg - DC_W'(1);
        end
    end

    // Block address: cleared per request, set on a successful pop
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            baddr_reg <= '0;
        end
        else if (cmd.pop)
        begin
            baddr_reg <= base_reg + ADDR_W'(mul_reg);
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            rsp_reg.status      <= cmd.code;
            rsp_reg.block_addr  <= baddr_reg;
            rsp_reg.free_blocks <= CNT_FIELD_W'(count_reg - top_reg);
        end
    end

    assign rsp = rsp_reg;

    // Status toward the controller
    assign flags.kind_free  = kind_reg;
    assign flags.oversize   = (len_reg > LEN_W'(size_reg));
    assign flags.empty      = (top_reg >= count_reg);
    assign flags.is_null    = (addr_reg == '0);
    assign flags.foreign    = below_reg || (off_reg > ADDR_W'(mul_reg));
    assign flags.div_last   = (dcnt_reg == '0);
    assign flags.misaligned = (rem_reg != '0);
    assign flags.bad_index  = (quo_reg >= count_reg);
    assign flags.top_zero   = (top_reg == '0);

endmodule

// ----- rtl/fixed_block_pool_allocator.sv -----
// Top level of the fixed-size block pool allocator.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_stall  | kind, request_len, free_addr
//   rsp     | out       | rsp_valid/rsp_stall  | status, block_addr, free_blocks
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A request taken in idle is evaluated and classified. One refused at
// classification goes straight to the output state, an allocate first pops
// the stack, and a free runs the divider one quotient bit per cycle and then
// a check; the next request is taken back in idle. Reset and every config
// write restore identity order at once through a fill mark, with no clearing
// pass. Config waits for an idle block with no word offered or waiting at the
// output. A finished word waits in the output register while the next request
// is taken; a stalled output holds the final state until free.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  fbpa_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output fbpa_pkg::rsp_t                 rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

    import fbpa_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;
    logic      cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_ready (cfg_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flags     (flags),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/fbpa_chk.sv -----
// Port-level checker for the allocator and its bind to the top level.
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input fbpa_pkg::rsp_t rsp,
    input logic           cfg_valid,
    input logic           cfg_ready
);

    import fbpa_pkg::*;

    // A stalled output word stays put
    `FBPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

    // Only one request in flight
    `FBPA_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "second request taken while busy")

    // Address is zero on every failing or free result
    `FBPA_ASSERT_SAME(a_addr_zero, rsp_valid && (rsp.status != ST_ALLOC_OK), rsp.block_addr == '0, "block_addr set without alloc ok")

    // An empty pool reports no free blocks
    `FBPA_ASSERT_SAME(a_empty_none, rsp_valid && (rsp.status == ST_EMPTY), rsp.free_blocks == '0, "empty status with free blocks left")

    // Config lands only while no word is offered or waiting
    `FBPA_ASSERT_SAME(a_cfg_quiet, cfg_valid && cfg_ready, !req_valid && !rsp_valid, "config taken while busy")

endmodule

bind fixed_block_pool_allocator fbpa_chk u_fbpa_chk (.*);
